// File: src/jss_pkg.sv
// Shared types, constants and helpers for the 3D Jacobi stencil sweep.
`timescale 1ns / 1ps
`default_nettype none

package jss_pkg;

    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 1024;

    localparam int X_W      = $clog2(MAX_X);
    localparam int Y_W      = $clog2(MAX_Y);
    localparam int Z_W      = $clog2(MAX_Z);
    localparam int PLANE_AW = X_W + Y_W;
    localparam int WIN_AW   = PLANE_AW + 1;

    localparam int DATA_W     = 32;
    localparam int SIZE_XY_W  = 7;
    localparam int SIZE_Z_W   = 11;
    localparam int SPACING_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIZE_XY_W-1:0] SIZE_X_MAX = SIZE_XY_W'(MAX_X);
    localparam logic [SIZE_XY_W-1:0] SIZE_Y_MAX = SIZE_XY_W'(MAX_Y);
    localparam logic [SIZE_Z_W-1:0]  SIZE_Z_MAX = SIZE_Z_W'(MAX_Z);

    localparam int TQ_DEPTH = 4;
    localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
    localparam int TQ_LVL_W = $clog2(TQ_DEPTH + 1);
    localparam int OQ_DEPTH = 16;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);
    localparam int PIPE_STAGES = 7;

    // ceil(2^21 / 3): exact quotient by 3 for any 19-bit value
    localparam logic [19:0] RECIP3 = 20'd699051;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X    = 3'd0,
        REG_SIZE_Y    = 3'd1,
        REG_SIZE_Z    = 3'd2,
        REG_SPACING_X = 3'd3,
        REG_SPACING_Y = 3'd4,
        REG_SPACING_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] grid_value;
        logic signed [DATA_W-1:0] source_value;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_value;
        logic                     sweep_last;
    } result_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // one interior point with all operands gathered
    typedef struct packed {
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] down;
        logic signed [DATA_W-1:0] west;
        logic signed [DATA_W-1:0] east;
        logic signed [DATA_W-1:0] south;
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] src;
        logic                     last;
    } task_t;

    function automatic logic [17:0] div3(input logic [18:0] v);
        logic [38:0] p;
        p = {20'b0, v} * {19'b0, RECIP3};
        return p[38:21];
    endfunction

endpackage

`default_nettype wire

// File: src/jss_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
`default_nettype none

module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/jss_front.sv
// Front end: raster counters, plane and source buffers, interior classification.
`timescale 1ns / 1ps
`default_nettype none

module jss_front import jss_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_wr_t             cfg,
    input  wire logic                push,
    input  wire sample_t             sample,
    output logic                     full,
    input  wire logic [TQ_LVL_W-1:0] tq_level,
    output logic                     tq_push,
    output task_t                    tq_data
);

    logic [SIZE_XY_W-1:0] size_x_reg, size_y_reg;
    logic [SIZE_Z_W-1:0]  size_z_reg;
    logic [SIZE_XY_W-1:0] nx, ny;
    logic [SIZE_Z_W-1:0]  nz;

    logic [X_W-1:0] col_reg, col_next;
    logic [Y_W-1:0] row_reg, row_next;
    logic [Z_W-1:0] plane_reg, plane_next;

    logic                 accept, interior, last;
    logic [SIZE_XY_W-1:0] x7, y7, xn, yn;
    logic [SIZE_Z_W-1:0]  z11, zn;

    logic [X_W-1:0]    xm, xp;
    logic [Y_W-1:0]    ym, yp;
    logic [WIN_AW-1:0] wa;
    logic              prev_slot;

    logic [DATA_W-1:0] down_rd, west_rd, east_rd, south_rd, north_rd, src_rd;

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [DATA_W-1:0] s1_grid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_XY_W'(64);
            size_y_reg <= SIZE_XY_W'(64);
            size_z_reg <= SIZE_Z_W'(64);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SIZE_X)
            begin
                size_x_reg <= cfg.data[SIZE_XY_W-1:0];
            end
            if (cfg.index == REG_SIZE_Y)
            begin
                size_y_reg <= cfg.data[SIZE_XY_W-1:0];
            end
            if (cfg.index == REG_SIZE_Z)
            begin
                size_z_reg <= cfg.data[SIZE_Z_W-1:0];
            end
        end
    end

    always_comb
    begin
        priority if (size_x_reg < SIZE_XY_W'(3))  nx = SIZE_XY_W'(3);
        else if (size_x_reg > SIZE_X_MAX)         nx = SIZE_X_MAX;
        else                                      nx = size_x_reg;
        priority if (size_y_reg < SIZE_XY_W'(3))  ny = SIZE_XY_W'(3);
        else if (size_y_reg > SIZE_Y_MAX)         ny = SIZE_Y_MAX;
        else                                      ny = size_y_reg;
        priority if (size_z_reg < SIZE_Z_W'(3))   nz = SIZE_Z_W'(3);
        else if (size_z_reg > SIZE_Z_MAX)         nz = SIZE_Z_MAX;
        else                                      nz = size_z_reg;
    end

    assign full   = ({1'b0, tq_level} + (TQ_LVL_W + 1)'(s1_valid_reg))
                    >= (TQ_LVL_W + 1)'(TQ_DEPTH);
    assign accept = push && !full;

    assign x7  = SIZE_XY_W'(col_reg);
    assign y7  = SIZE_XY_W'(row_reg);
    assign z11 = SIZE_Z_W'(plane_reg);

    assign interior = (x7 >= SIZE_XY_W'(1)) && (x7 + SIZE_XY_W'(2) <= nx)
                   && (y7 >= SIZE_XY_W'(1)) && (y7 + SIZE_XY_W'(2) <= ny)
                   && (z11 >= SIZE_Z_W'(2)) && (z11 + SIZE_Z_W'(1) <= nz);
    assign last = (x7 + SIZE_XY_W'(2) == nx) && (y7 + SIZE_XY_W'(2) == ny)
               && (z11 + SIZE_Z_W'(1) == nz);

    // raster advance; counters left beyond a shrunken size fold back to zero
    always_comb
    begin
        xn = x7 + SIZE_XY_W'(1);
        yn = y7;
        zn = z11;
        if (xn >= nx)
        begin
            xn = '0;
            yn = y7 + SIZE_XY_W'(1);
            if (yn >= ny)
            begin
                yn = '0;
                zn = z11 + SIZE_Z_W'(1);
                if (zn >= nz)
                begin
                    zn = '0;
                end
            end
        end
        if (yn >= ny)
        begin
            yn = '0;
        end
        if (zn >= nz)
        begin
            zn = '0;
        end
        col_next   = xn[X_W-1:0];
        row_next   = yn[Y_W-1:0];
        plane_next = zn[Z_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            plane_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                plane_reg <= plane_next;
            end
            s1_valid_reg <= accept && interior;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= last;
        s1_grid_reg <= sample.grid_value;
    end

    assign xm        = col_reg - X_W'(1);
    assign xp        = col_reg + X_W'(1);
    assign ym        = row_reg - Y_W'(1);
    assign yp        = row_reg + Y_W'(1);
    assign prev_slot = ~plane_reg[0];
    assign wa        = {plane_reg[0], row_reg, col_reg};

    // each copy holds the same two planes and serves one neighbor read
    jss_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_X * MAX_Y)) u_win_down (
        .clk(clk), .we(accept), .waddr(wa), .wdata(sample.grid_value),
        .raddr(wa), .rdata(down_rd));
    jss_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_X * MAX_Y)) u_win_west (
        .clk(clk), .we(accept), .waddr(wa), .wdata(sample.grid_value),
        .raddr({prev_slot, row_reg, xm}), .rdata(west_rd));
    jss_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_X * MAX_Y)) u_win_east (
        .clk(clk), .we(accept), .waddr(wa), .wdata(sample.grid_value),
        .raddr({prev_slot, row_reg, xp}), .rdata(east_rd));
    jss_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_X * MAX_Y)) u_win_south (
        .clk(clk), .we(accept), .waddr(wa), .wdata(sample.grid_value),
        .raddr({prev_slot, ym, col_reg}), .rdata(south_rd));
    jss_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_X * MAX_Y)) u_win_north (
        .clk(clk), .we(accept), .waddr(wa), .wdata(sample.grid_value),
        .raddr({prev_slot, yp, col_reg}), .rdata(north_rd));
    jss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_X * MAX_Y)) u_src (
        .clk(clk), .we(accept), .waddr(wa[PLANE_AW-1:0]),
        .wdata(sample.source_value), .raddr(wa[PLANE_AW-1:0]), .rdata(src_rd));

    assign tq_push       = s1_valid_reg;
    assign tq_data.up    = s1_grid_reg;
    assign tq_data.down  = $signed(down_rd);
    assign tq_data.west  = $signed(west_rd);
    assign tq_data.east  = $signed(east_rd);
    assign tq_data.south = $signed(south_rd);
    assign tq_data.north = $signed(north_rd);
    assign tq_data.src   = $signed(src_rd);
    assign tq_data.last  = s1_last_reg;

endmodule

`default_nettype wire

// File: src/jss_task_queue.sv
// Short queue of gathered stencil points between front and back.
`timescale 1ns / 1ps
`default_nettype none

module jss_task_queue import jss_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire task_t               push_data,
    input  wire logic                pop,
    output task_t                    head,
    output logic                     empty,
    output logic [TQ_LVL_W-1:0]      level
);

    task_t                entry_reg [TQ_DEPTH];
    logic [TQ_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [TQ_LVL_W-1:0]  level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + TQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + TQ_PTR_W'(1);
            end
            level_reg <= level_reg + TQ_LVL_W'(push) - TQ_LVL_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

`default_nettype wire

// File: src/jss_back.sv
// Back end: stencil arithmetic pipeline, weight coefficient, result queue.
`timescale 1ns / 1ps
`default_nettype none

module jss_back import jss_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_wr_t cfg,
    input  wire task_t   tq_head,
    input  wire logic    tq_empty,
    output logic         tq_pop,
    input  wire logic    pop,
    output logic         empty,
    output result_t      result
);

    localparam logic [35:0] DIV_OFS  = 36'h6_0000_0000;   // 3 * 2^33
    localparam logic signed [35:0] T1_OFS = 36'sh2_0000_0000;
    localparam logic signed [64:0] ROUND30 = 65'sd536870912;
    localparam logic signed [36:0] R_MAX = 37'sd2147483647;
    localparam logic signed [36:0] R_MIN = -37'sd2147483648;

    // spacing registers and the (dsum + 1) / 3 coefficient
    logic [SPACING_W-1:0] spacing_x_reg, spacing_y_reg, spacing_z_reg;
    logic [31:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [33:0] dsum1_reg;
    logic [17:0] kqh_reg, kqh2_reg, kqh3_reg;
    logic [16:0] khi_reg, klo_reg;
    logic [17:0] kql_reg;
    logic [18:0] krem_reg;
    logic [31:0] k_reg;
    logic [18:0] khi_diff;
    logic [34:0] k_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_x_reg <= SPACING_W'(2048);
            spacing_y_reg <= SPACING_W'(2048);
            spacing_z_reg <= SPACING_W'(2048);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SPACING_X)
            begin
                spacing_x_reg <= cfg.data;
            end
            if (cfg.index == REG_SPACING_Y)
            begin
                spacing_y_reg <= cfg.data;
            end
            if (cfg.index == REG_SPACING_Z)
            begin
                spacing_z_reg <= cfg.data;
            end
        end
    end

    assign khi_diff = {2'b0, khi_reg} - ({1'b0, kqh_reg} + {kqh_reg, 1'b0});
    assign k_sum    = {kqh3_reg, 17'b0} + {17'b0, kql_reg};

    always_ff @(posedge clk)
    begin
        sq_x_reg  <= {16'b0, spacing_x_reg} * {16'b0, spacing_x_reg};
        sq_y_reg  <= {16'b0, spacing_y_reg} * {16'b0, spacing_y_reg};
        sq_z_reg  <= {16'b0, spacing_z_reg} * {16'b0, spacing_z_reg};
        dsum1_reg <= {2'b0, sq_x_reg} + {2'b0, sq_y_reg} + {2'b0, sq_z_reg} + 34'd1;
        kqh_reg   <= div3({2'b0, dsum1_reg[33:17]});
        khi_reg   <= dsum1_reg[33:17];
        klo_reg   <= dsum1_reg[16:0];
        krem_reg  <= {khi_diff[1:0], klo_reg};
        kqh2_reg  <= kqh_reg;
        kql_reg   <= div3(krem_reg);
        kqh3_reg  <= kqh2_reg;
        k_reg     <= k_sum[31:0];
    end

    // result queue
    result_t              oq_entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  oq_wr_reg, oq_rd_reg;
    logic [OQ_LVL_W-1:0]  oq_level_reg;
    logic                 oq_pop;

    // arithmetic pipeline
    logic [PIPE_STAGES-1:0] valid_reg, last_reg;
    logic [OQ_LVL_W-1:0]    inflight;

    logic signed [35:0] p1_sum_reg, sum6;
    logic signed [DATA_W-1:0] p1_src_reg, p2_src_reg, p3_src_reg, p4_src_reg;
    logic [35:0]        p2_u_reg;
    logic signed [35:0] v_half;
    logic [17:0]        p3_qh_reg, p4_qh_reg, p5_qh_reg;
    logic [18:0]        p3_hi_reg, p4_rem_reg, rh_diff;
    logic [16:0]        p3_lo_reg;
    logic [17:0]        p5_ql_reg;
    logic signed [64:0] p5_prod_reg, prod, rnd;
    logic signed [35:0] p6_t1_reg;
    logic signed [34:0] p6_t2_reg;
    logic [34:0]        q_sum;
    logic signed [36:0] r_sum;
    logic signed [DATA_W-1:0] p7_r_reg, r_sat;

    always_comb
    begin
        inflight = '0;
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            inflight = inflight + OQ_LVL_W'(valid_reg[i]);
        end
    end

    assign tq_pop = !tq_empty
                 && ((oq_level_reg + inflight) < OQ_LVL_W'(OQ_DEPTH));

    assign sum6 = 36'(tq_head.up) + 36'(tq_head.down) + 36'(tq_head.west)
                + 36'(tq_head.east) + 36'(tq_head.south) + 36'(tq_head.north);
    // floor((s + 3) / 6) = floor(floor((s + 3) / 2) / 3); offset keeps it unsigned
    assign v_half  = (p1_sum_reg + 36'sd3) >>> 1;
    assign rh_diff = p3_hi_reg - ({1'b0, p3_qh_reg} + {p3_qh_reg, 1'b0});
    assign prod    = $signed({1'b0, k_reg}) * p4_src_reg;
    assign q_sum   = {p5_qh_reg, 17'b0} + {17'b0, p5_ql_reg};
    assign rnd     = p5_prod_reg + ROUND30;
    assign r_sum   = 37'(p6_t1_reg) + 37'(p6_t2_reg);

    always_comb
    begin
        priority if (r_sum > R_MAX) r_sat = R_MAX[DATA_W-1:0];
        else if (r_sum < R_MIN)     r_sat = R_MIN[DATA_W-1:0];
        else                        r_sat = r_sum[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], tq_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= {last_reg[PIPE_STAGES-2:0], tq_head.last};
        p1_sum_reg  <= sum6;
        p1_src_reg  <= tq_head.src;
        p2_u_reg    <= 36'(v_half) + DIV_OFS;
        p2_src_reg  <= p1_src_reg;
        p3_qh_reg   <= div3(p2_u_reg[35:17]);
        p3_hi_reg   <= p2_u_reg[35:17];
        p3_lo_reg   <= p2_u_reg[16:0];
        p3_src_reg  <= p2_src_reg;
        p4_rem_reg  <= {rh_diff[1:0], p3_lo_reg};
        p4_qh_reg   <= p3_qh_reg;
        p4_src_reg  <= p3_src_reg;
        p5_ql_reg   <= div3(p4_rem_reg);
        p5_qh_reg   <= p4_qh_reg;
        p5_prod_reg <= prod;
        p6_t1_reg   <= $signed({1'b0, q_sum}) - T1_OFS;
        p6_t2_reg   <= rnd[64:30];
        p7_r_reg    <= r_sat;
    end

    assign oq_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_level_reg <= '0;
        end
        else
        begin
            if (valid_reg[PIPE_STAGES-1])
            begin
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            end
            oq_level_reg <= oq_level_reg + OQ_LVL_W'(valid_reg[PIPE_STAGES-1])
                          - OQ_LVL_W'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg[PIPE_STAGES-1])
        begin
            oq_entry_reg[oq_wr_reg] <= '{new_value: p7_r_reg,
                                         sweep_last: last_reg[PIPE_STAGES-1]};
        end
    end

    assign result = oq_entry_reg[oq_rd_reg];
    assign empty  = (oq_level_reg == '0);

endmodule

`default_nettype wire

// File: src/jacobi_stencil_3d_sweep.sv
// An interior item's result passes the task queue, the pipeline and the result queue.
// Throughput: one item per cycle while full is low; every input item is one raster
// sample, and the plane buffers take one write and their neighbor reads in the same cycle.
// Items on the border and in the first two planes give no result.
// Reset (rst_n low, asynchronous) clears counters and queues and restores the
// register defaults; buffer contents are kept and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_stencil_3d_sweep import jss_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire sample_t               sample,
    output logic                       empty,
    input  wire logic                  pop,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_wr_t             cfg;
    task_t               tq_in, tq_head;
    logic                tq_push, tq_pop, tq_empty;
    logic [TQ_LVL_W-1:0] tq_level;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    jss_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .push(push), .sample(sample),
        .full(full), .tq_level(tq_level), .tq_push(tq_push), .tq_data(tq_in));

    jss_task_queue u_task_queue (
        .clk(clk), .rst_n(rst_n), .push(tq_push), .push_data(tq_in),
        .pop(tq_pop), .head(tq_head), .empty(tq_empty), .level(tq_level));

    jss_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .tq_head(tq_head),
        .tq_empty(tq_empty), .tq_pop(tq_pop), .pop(pop), .empty(empty),
        .result(result));

endmodule

`default_nettype wire

// File: src/jss_checker.sv
// Port-level checks for the stencil sweep block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jss_checker import jss_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    full,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // a waiting result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // queues are cleared while reset is held
    assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    assert property (@(posedge clk) !rst_n |-> !full)
        else $error("input blocked during reset");

endmodule

bind jacobi_stencil_3d_sweep jss_checker u_checker (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
    .result(result));

`default_nettype wire

// File: tb/sv/jacobi_stencil_3d_sweep_test.sv
// Testbench for the 3D Jacobi stencil sweep: queue-style drive, predictor and scoreboard.
`timescale 1ns / 1ps

module jacobi_stencil_3d_sweep_test;
    import jss_pkg::*;

    class stencil_scoreboard;
        int unsigned size_x, size_y, size_z;
        longint unsigned spacing_x, spacing_y, spacing_z;
        int grid_planes[2*MAX_X*MAX_Y];
        int source_plane[MAX_X*MAX_Y];
        int unsigned col, row, plane;
        result_t pending_results[$];
        int errors;
        int checked;

        function new();
            size_x = 64;
            size_y = 64;
            size_z = 64;
            spacing_x = 2048;
            spacing_y = 2048;
            spacing_z = 2048;
            col = 0;
            row = 0;
            plane = 0;
            errors = 0;
            checked = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        function int unsigned clamp_size(input int unsigned v, input int unsigned hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned nx();
            return clamp_size(size_x, MAX_X);
        endfunction

        function int unsigned ny();
            return clamp_size(size_y, MAX_Y);
        endfunction

        function int unsigned nz();
            return clamp_size(size_z, MAX_Z);
        endfunction

        function void write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SIZE_X:    size_x = val & 16'h7F;
                REG_SIZE_Y:    size_y = val & 16'h7F;
                REG_SIZE_Z:    size_z = val & 16'h7FF;
                REG_SPACING_X: spacing_x = val;
                REG_SPACING_Y: spacing_y = val;
                REG_SPACING_Z: spacing_z = val;
                default: ;
            endcase
        endfunction

        function int unsigned win_addr(input int unsigned slot, input int unsigned x,
                                       input int unsigned y);
            return (slot & 1) * MAX_X * MAX_Y + y * MAX_X + x;
        endfunction

        // one raster sample in; new value of the point one plane below, if interior
        function void note_sample(input sample_t s);
            int unsigned x, y, z;
            longint sum6, src, k, t1, t2, r;
            longint unsigned dsum;
            result_t res;
            x = col;
            y = row;
            z = plane;
            if (x >= 1 && x + 2 <= nx() && y >= 1 && y + 2 <= ny() && z >= 2 && z + 1 <= nz())
            begin
                sum6 = longint'(s.grid_value)
                     + grid_planes[win_addr(z, x, y)]
                     + grid_planes[win_addr(z - 1, x - 1, y)]
                     + grid_planes[win_addr(z - 1, x + 1, y)]
                     + grid_planes[win_addr(z - 1, x, y - 1)]
                     + grid_planes[win_addr(z - 1, x, y + 1)];
                src = source_plane[y * MAX_X + x];
                dsum = spacing_x * spacing_x + spacing_y * spacing_y + spacing_z * spacing_z;
                k = longint'((dsum + 1) / 3);
                t1 = (sum6 + 3) / 6;
                if ((sum6 + 3) % 6 != 0 && sum6 + 3 < 0)
                    t1 = t1 - 1;
                t2 = (k * src + (longint'(1) << 29)) >>> 30;
                r = t1 + t2;
                if (r > 64'sd2147483647)
                    r = 64'sd2147483647;
                if (r < -64'sd2147483648)
                    r = -64'sd2147483648;
                res.new_value = r[31:0];
                res.sweep_last = (x + 2 == nx() && y + 2 == ny() && z + 1 == nz());
                pending_results.push_back(res);
            end
            grid_planes[win_addr(z, x, y)] = s.grid_value;
            source_plane[y * MAX_X + x] = s.source_value;
            x++;
            if (x >= nx()) begin
                x = 0;
                y++;
                if (y >= ny()) begin
                    y = 0;
                    z++;
                    if (z >= nz())
                        z = 0;
                end
            end
            if (y >= ny())
                y = 0;
            if (z >= nz())
                z = 0;
            col = x;
            row = y;
            plane = z;
        endfunction

        task check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected item new_value=%0d last=%0b",
                                 got.new_value, got.sweep_last));
            end
            else begin
                want = pending_results.pop_front();
                checked++;
                if (got.new_value !== want.new_value)
                    report($sformatf("new_value got %0d want %0d",
                                     got.new_value, want.new_value));
                if (got.sweep_last !== want.sweep_last)
                    report($sformatf("sweep_last got %0b want %0b",
                                     got.sweep_last, want.sweep_last));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    sample_t sample;
    logic empty;
    logic pop;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stencil_scoreboard sb;
    bit steady;
    bit long_hold_done;
    int samples_sent;

    jacobi_stencil_3d_sweep i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] pick_value(input int mode);
        if (mode == 1) begin
            case ($urandom_range(0, 4))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h0;
                3: return 32'hFFFFFFFF;
                default: return 32'h1;
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        return $urandom;
    endfunction

    task automatic write_cfg(input cfg_reg_t idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val[CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(input sample_t s);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (full);
        sb.note_sample(s);
        samples_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        // trailing border items may still be in flight
        repeat (20) @(posedge clk);
    endtask

    task automatic run_sweeps(input int unsigned sx, input int unsigned sy,
                              input int unsigned sz, input int unsigned spx,
                              input int unsigned spy, input int unsigned spz,
                              input int sweeps, input int mode, input bit pause_mid);
        int total;
        sample_t s;
        write_cfg(REG_SIZE_X, sx);
        write_cfg(REG_SIZE_Y, sy);
        write_cfg(REG_SIZE_Z, sz);
        write_cfg(REG_SPACING_X, spx);
        write_cfg(REG_SPACING_Y, spy);
        write_cfg(REG_SPACING_Z, spz);
        total = sweeps * sb.nx() * sb.ny() * sb.nz();
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < total; i++) begin
            if (pause_mid && i == total / 2) begin
                @(negedge clk);
                push <= 1'b0;
                while (sb.pending_results.size() != 0)
                    @(posedge clk);
            end
            s.grid_value = pick_value(mode);
            s.source_value = pick_value(mode);
            push_sample(s);
        end
        drain();
    endtask

    // result side: random pops, plus one long hold so the block backs up
    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && sb.checked >= 20) begin
                long_hold_done = 1;
                @(negedge clk);
                pop <= 1'b0;
                repeat (300) @(posedge clk);
            end
            gap = steady ? 0 : $urandom_range(0, 3);
            repeat (gap)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            sb.check_result(result);
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 0;
        long_hold_done = 0;
        samples_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // smallest grid, extreme values, largest spacing: a single result that may saturate
        run_sweeps(3, 3, 3, 65535, 65535, 65535, 1, 1, 0);
        // sizes below range clamp to 3, zero spacing
        run_sweeps(0, 1, 2, 0, 0, 0, 2, 0, 0);
        run_sweeps(127, 3, 3, $urandom_range(0, 65535), 2048, 65535, 1, 0, 0);
        run_sweeps(3, 127, 3, 1, 32768, $urandom_range(0, 65535), 1, 0, 1);
        run_sweeps(6, 5, 4, $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), 1, 0, 0);
        run_sweeps(3, 3, 4, $urandom_range(0, 4096), $urandom_range(0, 4096),
                   $urandom_range(0, 4096), 1, 0, 0);
        for (int p = 0; p < 4; p++)
            run_sweeps($urandom_range(3, 5), $urandom_range(3, 5), $urandom_range(3, 4),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), 1, $urandom_range(0, 3) == 0, 0);

        $display("Covered %0d samples and %0d results over several grid shapes,",
                 samples_sent, sb.checked);
        $display("spacings from 0 to full scale, saturation, clamped sizes and back-pressure.");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
